@@ design/stack_machine_executor_core_assert.svh @@
// Assertion macros used by the checker file sme_checker.sv.
`ifndef STACK_MACHINE_EXECUTOR_CORE_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_CORE_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SME_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define SME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/sme_pkg.sv @@
// ----------------------------------------------------------------------------
// sme_pkg
// Opcodes, status codes and sizing constants of the stack machine executor.
// ----------------------------------------------------------------------------
package sme_pkg;
  localparam int unsigned DefDataStackDepth   = 64;
  localparam int unsigned DefReturnStackDepth = 16;
  localparam int unsigned DefRegisterCount    = 4;
  localparam int unsigned DefRamWords         = 1024;

  localparam logic [4:0] OP_PUSH = 5'd0,  OP_POP  = 5'd1,  OP_ADD  = 5'd2,
                         OP_SUB  = 5'd3,  OP_MUL  = 5'd4,  OP_DIV  = 5'd5,
                         OP_SQRT = 5'd6,  OP_OUT  = 5'd7,  OP_IN   = 5'd8,
                         OP_PUSHR = 5'd9, OP_POPR = 5'd10, OP_JMP  = 5'd11,
                         OP_JB   = 5'd12, OP_JBE  = 5'd13, OP_JA   = 5'd14,
                         OP_JAE  = 5'd15, OP_JE   = 5'd16, OP_JNE  = 5'd17,
                         OP_CALL = 5'd18, OP_RET  = 5'd19, OP_PUSHM = 5'd20,
                         OP_POPM = 5'd21;

  localparam logic [3:0] ST_OK = 4'd0, ST_NOARG = 4'd1, ST_UNDER = 4'd2,
                         ST_DIVZ = 4'd3, ST_SQNEG = 4'd4, ST_BADJMP = 4'd5,
                         ST_NEGCALL = 4'd6, ST_DOVF = 4'd8, ST_ROVF = 4'd9,
                         ST_REMPTY = 4'd10;

  // Mode of the shared iterative unit.
  typedef enum logic [1:0] {ITER_DIV, ITER_SQRT} iter_mode_e;

  typedef struct packed {
    logic       start;
    iter_mode_e mode;
  } iter_ctl_t;
endpackage

@@ design/stack_machine_executor_core.sv @@
// Most instructions pass operand read (S_READ), execute (S_EXEC) and the
// result register (S_OUT); RAM reads add S_RAMA and S_RAMD, mul adds S_MUL;
// div and sqrt wait in S_ITER on the bit-serial shared divide/root unit.
// One instruction at a time, a new request only after the last result is
// accepted; s_axis_tready is high only in the idle state. After reset a
// clearing pass zeroes the data RAM, during which no request is taken.
// ----------------------------------------------------------------------------
// stack_machine_executor_core
// Stack machine instruction executor with stacks, registers and data RAM.
// ----------------------------------------------------------------------------
module stack_machine_executor_core
  import sme_pkg::*;
#(
  parameter int unsigned DATA_STACK_DEPTH   = DefDataStackDepth,
  parameter int unsigned RETURN_STACK_DEPTH = DefReturnStackDepth,
  parameter int unsigned REGISTER_COUNT     = DefRegisterCount,
  parameter int unsigned RAM_WORDS          = DefRamWords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] command, [36:5] argument, [68:37] input_value, [71:69] zero
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] next_ip, [19:16] status, [20] out_valid, [52:21] out_value, [55:53] zero
  output logic [55:0] m_axis_tdata
);
  localparam int unsigned DW = $clog2(DATA_STACK_DEPTH);
  localparam int unsigned DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int unsigned RW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
  localparam int unsigned RDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int unsigned GW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int unsigned AW = $clog2(RAM_WORDS);
  localparam int unsigned AWC = $clog2(RAM_WORDS + 1);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2,
                         S_EXEC = 4'd3, S_RAMA = 4'd4, S_RAMD = 4'd5,
                         S_MUL = 4'd6, S_ITER = 4'd7, S_OUT = 4'd8;

  logic [3:0] state_q, state_d;
  logic [15:0] plen_q, ip_q, ip_d;
  logic [DDW-1:0] dd_q, dd_d;
  logic [RDW-1:0] rd_q, rd_d;
  logic [31:0] gpr_q [REGISTER_COUNT];
  logic [AWC-1:0] clr_q;

  logic [31:0] dmem [DATA_STACK_DEPTH];
  logic [15:0] rmem [RETURN_STACK_DEPTH];
  logic [31:0] ram [RAM_WORDS];

  logic [4:0]  cmd_q;
  logic [31:0] arg_q, inv_q, a_q, b_q, ramd_q, r_q;
  logic [15:0] rret_q;
  logic [55:0] out_q;
  logic        ovalid_q;

  // Shared unit glue.
  iter_ctl_t   ictl;
  logic        idone;
  logic [31:0] ires, ia, ib;
  logic        neg_q;

  // Write ports of the data stack, return stack and data RAM.
  logic          ds_we;
  logic [DW-1:0] ds_wa;
  logic [31:0]   ds_wd;
  logic          rs_we;
  logic [RW-1:0] rs_wa;
  logic          ram_we;
  logic [AW-1:0] ram_wa;
  logic [31:0]   ram_wd;

  logic [15:0] ip1, ip2;
  logic        has_arg, arg_bad, cond;
  logic [GW-1:0] ridx;
  logic [3:0]  st;
  logic [15:0] nip;
  logic        take_res;
  logic [31:0] ma, mb;

  assign ip1 = ip_q + 16'd1;
  assign ip2 = ip_q + 16'd2;
  assign has_arg = ({1'b0, ip_q} + 17'd1) < {1'b0, plen_q};
  assign arg_bad = arg_q[31] || (arg_q >= {16'd0, plen_q});
  assign ridx = GW'(arg_q % REGISTER_COUNT);
  assign ma = a_q[31] ? (32'd0 - a_q) : a_q;
  assign mb = b_q[31] ? (32'd0 - b_q) : b_q;

  always_comb begin
    unique case (cmd_q)
      OP_JB:  cond = $signed(b_q) < $signed(a_q);
      OP_JBE: cond = !($signed(a_q) < $signed(b_q));
      OP_JA:  cond = $signed(a_q) < $signed(b_q);
      OP_JAE: cond = !($signed(b_q) < $signed(a_q));
      OP_JE:  cond = (a_q == b_q);
      default: cond = (a_q != b_q);
    endcase
  end

  assign ia = (cmd_q == OP_SQRT) ? a_q : mb;
  assign ib = ma;

  sme_iter_unit u_iter (
    .clk_i, .rst_ni, .ctl_i(ictl), .a_i(ia), .b_i(ib),
    .done_o(idone), .res_o(ires)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_d = state_q; ip_d = ip_q; dd_d = dd_q; rd_d = rd_q;
    ds_we = 1'b0; ds_wa = '0; ds_wd = '0;
    rs_we = 1'b0; rs_wa = '0;
    ram_we = 1'b0; ram_wa = '0; ram_wd = '0;
    ictl = '{start: 1'b0, mode: ITER_DIV};
    st = ST_OK; nip = ip1; take_res = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1; ram_wa = clr_q[AW-1:0];
        if (clr_q == AWC'(RAM_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (s_axis_tvalid) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_OUT: if (m_axis_tready) state_d = S_IDLE;
      S_RAMA: state_d = S_RAMD;
      S_MUL, S_RAMD, S_ITER, S_EXEC: begin
        state_d = S_OUT; take_res = 1'b1;
        unique case (cmd_q)
          OP_PUSH, OP_IN, OP_PUSHR, OP_PUSHM: begin
            if (cmd_q != OP_IN && !has_arg) st = ST_NOARG;
            else if (dd_q >= DDW'(DATA_STACK_DEPTH)) st = ST_DOVF;
            else if (cmd_q == OP_PUSHM && state_q == S_EXEC) begin
              state_d = S_RAMA; take_res = 1'b0;
            end else begin
              ds_we = 1'b1; ds_wa = dd_q[DW-1:0];
              ds_wd = (cmd_q == OP_PUSH) ? arg_q : (cmd_q == OP_IN) ? inv_q :
                      (cmd_q == OP_PUSHR) ? gpr_q[ridx] : ramd_q;
              dd_d = dd_q + DDW'(1);
              nip = (cmd_q == OP_IN) ? ip1 : ip2;
            end
          end
          OP_POP, OP_OUT: begin
            if (dd_q < DDW'(1)) st = ST_UNDER;
            else dd_d = dd_q - DDW'(1);
          end
          OP_POPR, OP_POPM: begin
            if (!has_arg) st = ST_NOARG;
            else if (dd_q < DDW'(1)) st = ST_UNDER;
            else begin
              dd_d = dd_q - DDW'(1); nip = ip2;
              if (cmd_q == OP_POPM) begin
                ram_we = 1'b1; ram_wa = AW'(gpr_q[ridx] % RAM_WORDS); ram_wd = a_q;
              end
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (dd_q < DDW'(2)) st = ST_UNDER;
            else if (cmd_q == OP_DIV && a_q == 32'd0) st = ST_DIVZ;
            else if (cmd_q == OP_MUL && state_q == S_EXEC) begin
              state_d = S_MUL; take_res = 1'b0;
            end else if (cmd_q == OP_DIV && state_q == S_EXEC) begin
              state_d = S_ITER; take_res = 1'b0;
              ictl = '{start: 1'b1, mode: ITER_DIV};
            end else if (cmd_q == OP_DIV && !idone) begin
              state_d = S_ITER; take_res = 1'b0;
            end else begin
              dd_d = dd_q - DDW'(1);
              ds_we = 1'b1; ds_wa = DW'(dd_q - DDW'(2));
              ds_wd = (cmd_q == OP_ADD) ? b_q + a_q : (cmd_q == OP_SUB) ? b_q - a_q :
                      (cmd_q == OP_MUL) ? r_q : (neg_q ? 32'd0 - ires : ires);
            end
          end
          OP_SQRT: begin
            if (dd_q < DDW'(1)) st = ST_UNDER;
            else if (a_q[31]) st = ST_SQNEG;
            else if (state_q == S_EXEC) begin
              state_d = S_ITER; take_res = 1'b0;
              ictl = '{start: 1'b1, mode: ITER_SQRT};
            end else if (!idone) begin
              state_d = S_ITER; take_res = 1'b0;
            end else begin
              ds_we = 1'b1; ds_wa = DW'(dd_q - DDW'(1)); ds_wd = ires;
            end
          end
          OP_JMP: begin
            if (!has_arg) st = ST_NOARG;
            else if (arg_bad) st = ST_BADJMP;
            else nip = arg_q[15:0];
          end
          OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
            if (dd_q < DDW'(2)) st = ST_UNDER;
            else if (!has_arg) st = ST_NOARG;
            else if (cond && arg_bad) st = ST_BADJMP;
            else begin
              nip = cond ? arg_q[15:0] : ip2; dd_d = dd_q - DDW'(2);
            end
          end
          OP_CALL: begin
            if (!has_arg) st = ST_NOARG;
            else if (arg_q[31]) st = ST_NEGCALL;
            else if (arg_bad) st = ST_BADJMP;
            else if (rd_q >= RDW'(RETURN_STACK_DEPTH)) st = ST_ROVF;
            else begin
              rs_we = 1'b1; rs_wa = rd_q[RW-1:0]; rd_d = rd_q + RDW'(1);
              nip = arg_q[15:0];
            end
          end
          OP_RET: begin
            if (rd_q < RDW'(1)) st = ST_REMPTY;
            else begin
              rd_d = rd_q - RDW'(1); nip = rret_q;
            end
          end
          default: nip = ip1;
        endcase
        if (st != ST_OK) nip = ip_q;
        if (take_res) ip_d = nip;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; plen_q <= '0; ip_q <= '0; dd_q <= '0; rd_q <= '0;
      clr_q <= '0; ovalid_q <= 1'b0;
      for (int i = 0; i < int'(REGISTER_COUNT); i++) gpr_q[i] <= '0;
    end else begin
      state_q <= state_d; ip_q <= ip_d; dd_q <= dd_d; rd_q <= rd_d;
      if (cfg_we_i) plen_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + AWC'(1);
      if (take_res) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      if (take_res && st == ST_OK && cmd_q == OP_POPR) gpr_q[ridx] <= a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      cmd_q <= s_axis_tdata[4:0];
      arg_q <= s_axis_tdata[36:5];
      inv_q <= s_axis_tdata[68:37];
    end
    if (state_q == S_READ) begin
      a_q    <= dmem[DW'(dd_q - DDW'(1))];
      b_q    <= dmem[DW'(dd_q - DDW'(2))];
      rret_q <= rmem[RW'(rd_q - RDW'(1))];
    end
    if (state_q == S_EXEC) neg_q <= a_q[31] ^ b_q[31];
    // The product is ready for the write back in the multiply state.
    if (state_q == S_EXEC) r_q <= b_q * a_q;
    if (state_q == S_RAMA) ramd_q <= ram[AW'(gpr_q[ridx] % RAM_WORDS)];
    if (ds_we) dmem[ds_wa] <= ds_wd;
    if (rs_we) rmem[rs_wa] <= ip2;
    if (ram_we) ram[ram_wa] <= ram_wd;
    if (take_res) begin
      out_q <= {3'd0,
                (st == ST_OK && cmd_q == OP_OUT) ? a_q : 32'd0,
                (st == ST_OK && cmd_q == OP_OUT), st, nip};
    end
  end
endmodule

@@ design/sme_iter_unit.sv @@
// ----------------------------------------------------------------------------
// sme_iter_unit
// Shared iterative unit: unsigned restoring divide or floor square root,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module sme_iter_unit
  import sme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  iter_ctl_t   ctl_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        sqrt_q, sqrt_d;
  logic [31:0] num_q, num_d, den_q, den_d, res_q, res_d;
  logic [33:0] rem_q, rem_d;
  logic [33:0] trial, shifted;

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; sqrt_d = sqrt_q;
    num_d = num_q; den_d = den_q; res_d = res_q; rem_d = rem_q;
    shifted = '0; trial = '0;
    done_o = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1; cnt_d = '0; sqrt_d = (ctl_i.mode == ITER_SQRT);
      num_d = a_i; den_d = b_i; res_d = '0; rem_d = '0;
    end else if (busy_q) begin
      if (sqrt_q) begin
        // Two radicand bits per step, 16 steps.
        shifted = {rem_q[31:0], num_q[31:30]};
        trial   = {res_q[31:0], 2'b01};
        num_d   = {num_q[29:0], 2'b00};
        if (shifted >= trial) begin
          rem_d = shifted - trial; res_d = {res_q[30:0], 1'b1};
        end else begin
          rem_d = shifted; res_d = {res_q[30:0], 1'b0};
        end
      end else begin
        shifted = {rem_q[32:0], num_q[31]};
        trial   = {2'b00, den_q};
        num_d   = {num_q[30:0], 1'b0};
        if (shifted >= trial) begin
          rem_d = shifted - trial; res_d = {res_q[30:0], 1'b1};
        end else begin
          rem_d = shifted; res_d = {res_q[30:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 6'd1;
      if ((sqrt_q && cnt_q == 6'd15) || (!sqrt_q && cnt_q == 6'd31)) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign res_o = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; den_q <= den_d; res_q <= res_d; rem_q <= rem_d;
  end
endmodule

@@ design/sme_checker.sv @@
// ----------------------------------------------------------------------------
// sme_checker
// Port-level checks of the executor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "stack_machine_executor_core_assert.svh"
module sme_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  // A request is never taken while a result is still pending.
  `SME_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  // A taken request keeps the input closed in the next cycle.
  `SME_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                   !s_axis_tready)
  // out_valid is only reported together with an ok status.
  `SME_ASSERT_IMP(a_out_ok, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[20],
                  m_axis_tdata[19:16] == 4'd0)
  // A stalled result holds its payload.
  `SME_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   $stable(m_axis_tdata))
endmodule

bind stack_machine_executor_core sme_checker u_sme_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Drives instruction requests on the input stream and checks each result
// against a built-in model of the instruction pointer, stacks, registers and
// data RAM. Directed requests cover most opcodes and error cases, then random
// short programs run under several program lengths with random stalls.
// ----------------------------------------------------------------------------
module tb;
  import sme_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] inval;
    logic [31:0] arg;
    logic [4:0]  cmd;
  } instr_t;

  typedef struct packed {
    logic [31:0] oval;
    logic        ovld;
    logic [3:0]  st;
    logic [15:0] nip;
  } result_t;

  // A queue entry is either an instruction or a program length write.
  typedef struct {
    bit          is_cfg;
    logic [15:0] plen;
    instr_t      ins;
  } job_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [55:0] m_axis_tdata;

  stack_machine_executor_core uut (.*);

  always #10 clk_i = ~clk_i;

  // Model state.
  logic [15:0] m_plen, m_ip;
  logic [31:0] m_dstk [64];
  int          m_dd;
  logic [15:0] m_rstk [16];
  int          m_rd;
  logic [31:0] m_regs [4];
  logic [31:0] m_ram [1024];

  job_t    jobs[$];
  result_t expected_results[$];
  int      mismatches = 0, n_results = 0, n_out = 0, n_err = 0;
  bit      hold_off = 0;

  function automatic logic [31:0] isqrt(logic [31:0] v);
    logic [31:0] res, bt;
    res = 0;
    bt = 32'h4000_0000;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic result_t execute_instr(instr_t i);
    result_t r;
    logic [15:0] ip1, ip2;
    logic [31:0] a, b, v;
    logic [1:0]  ri;
    bit has_arg, neg, cond;
    logic [3:0] st;
    logic [15:0] nip;
    ip1 = m_ip + 16'd1;
    ip2 = m_ip + 16'd2;
    has_arg = (32'(m_ip) + 1) < 32'(m_plen);
    neg = i.arg[31];
    ri = i.arg[1:0];
    st = ST_OK;
    nip = m_ip;
    r = '0;
    cond = 0;
    case (i.cmd)
      OP_PUSH, OP_IN, OP_PUSHR, OP_PUSHM: begin
        if (i.cmd != OP_IN && !has_arg) st = ST_NOARG;
        else if (m_dd >= 64) st = ST_DOVF;
        else begin
          if (i.cmd == OP_PUSH) v = i.arg;
          else if (i.cmd == OP_IN) v = i.inval;
          else if (i.cmd == OP_PUSHR) v = m_regs[ri];
          else v = m_ram[m_regs[ri][9:0]];
          m_dstk[m_dd++] = v;
          nip = (i.cmd == OP_IN) ? ip1 : ip2;
        end
      end
      OP_POP, OP_OUT: begin
        if (m_dd < 1) st = ST_UNDER;
        else begin
          v = m_dstk[--m_dd];
          if (i.cmd == OP_OUT) begin
            r.ovld = 1;
            r.oval = v;
          end
          nip = ip1;
        end
      end
      OP_POPR, OP_POPM: begin
        if (!has_arg) st = ST_NOARG;
        else if (m_dd < 1) st = ST_UNDER;
        else begin
          v = m_dstk[--m_dd];
          if (i.cmd == OP_POPR) m_regs[ri] = v;
          else m_ram[m_regs[ri][9:0]] = v;
          nip = ip2;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (m_dd < 2) st = ST_UNDER;
        else begin
          a = m_dstk[m_dd-1];
          b = m_dstk[m_dd-2];
          if (i.cmd == OP_DIV && a == 0) st = ST_DIVZ;
          else begin
            if (i.cmd == OP_ADD) v = b + a;
            else if (i.cmd == OP_SUB) v = b - a;
            else if (i.cmd == OP_MUL) v = b * a;
            else if (b == 32'h8000_0000 && a == '1) v = b;
            else v = $signed(b) / $signed(a);
            m_dd--;
            m_dstk[m_dd-1] = v;
            nip = ip1;
          end
        end
      end
      OP_SQRT: begin
        if (m_dd < 1) st = ST_UNDER;
        else if (m_dstk[m_dd-1][31]) st = ST_SQNEG;
        else begin
          m_dstk[m_dd-1] = isqrt(m_dstk[m_dd-1]);
          nip = ip1;
        end
      end
      OP_JMP: begin
        if (!has_arg) st = ST_NOARG;
        else if (neg || i.arg >= 32'(m_plen)) st = ST_BADJMP;
        else nip = i.arg[15:0];
      end
      OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
        if (m_dd < 2) st = ST_UNDER;
        else if (!has_arg) st = ST_NOARG;
        else begin
          a = m_dstk[m_dd-1];
          b = m_dstk[m_dd-2];
          case (i.cmd)
            OP_JB:   cond = $signed(b) < $signed(a);
            OP_JBE:  cond = $signed(b) <= $signed(a);
            OP_JA:   cond = $signed(b) > $signed(a);
            OP_JAE:  cond = $signed(b) >= $signed(a);
            OP_JE:   cond = a == b;
            default: cond = a != b;
          endcase
          if (cond && (neg || i.arg >= 32'(m_plen))) st = ST_BADJMP;
          else begin
            nip = cond ? i.arg[15:0] : ip2;
            m_dd -= 2;
          end
        end
      end
      OP_CALL: begin
        if (!has_arg) st = ST_NOARG;
        else if (neg) st = ST_NEGCALL;
        else if (i.arg >= 32'(m_plen)) st = ST_BADJMP;
        else if (m_rd >= 16) st = ST_ROVF;
        else begin
          m_rstk[m_rd++] = ip2;
          nip = i.arg[15:0];
        end
      end
      OP_RET: begin
        if (m_rd < 1) st = ST_REMPTY;
        else nip = m_rstk[--m_rd];
      end
      default: nip = ip1;
    endcase
    if (st != ST_OK) nip = m_ip;
    m_ip = nip;
    r.nip = nip;
    r.st = st;
    return r;
  endfunction

  function automatic void add_instr(logic [4:0] c, logic [31:0] a, logic [31:0] iv = '0);
    job_t j;
    j.is_cfg = 0;
    j.plen = '0;
    j.ins = '{inval: iv, arg: a, cmd: c};
    jobs.push_back(j);
  endfunction

  function automatic void add_cfg(logic [15:0] p);
    job_t j;
    j.is_cfg = 1;
    j.plen = p;
    j.ins = '0;
    jobs.push_back(j);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 20);
      3: return -$urandom_range(1, 20);
      default: return $urandom;
    endcase
  endfunction

  // Random items: one in four a value push, most others a random known opcode
  // (consumers, jumps, calls, register and RAM traffic), and some unknown opcodes.
  function automatic void add_random(int plen);
    logic [4:0] c;
    logic [31:0] a;
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) c = $urandom_range(0, 1) ? OP_PUSH : OP_IN;
    else if (k < 97) c = 5'($urandom_range(1, 21));
    else c = 5'($urandom_range(22, 31));
    case ($urandom_range(0, 3))
      0: a = $urandom_range(0, plen + 2);
      1: a = $urandom_range(0, 7);
      2: a = rand_word();
      default: a = $urandom;
    endcase
    add_instr(c, a, rand_word());
  endfunction

  // Driver: one request at a time from the job queue; writes wait for idle.
  int gap = 0;
  always @(posedge clk_i) begin
    bit next_valid, next_we;
    if (rst_ni) begin
      next_valid = s_axis_tvalid && !s_axis_tready;
      next_we = 0;
      if (gap > 0) gap <= gap - 1;
      else if (!next_valid && jobs.size() > 0 && !hold_off) begin
        if (jobs[0].is_cfg) begin
          if (expected_results.size() == 0 && !s_axis_tvalid) begin
            next_we = 1;
            cfg_wdata_i <= jobs[0].plen;
            m_plen = jobs[0].plen;
            void'(jobs.pop_front());
            gap <= 50;
          end
        end else begin
          next_valid = 1;
          s_axis_tdata <= {3'b0, jobs[0].ins};
          expected_results.push_back(execute_instr(jobs[0].ins));
          void'(jobs.pop_front());
          gap <= ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3)) : 0;
        end
      end
      s_axis_tvalid <= next_valid;
      cfg_we_i <= next_we;
    end
  end

  // Monitor with random backpressure, mostly short stalls and a few long ones.
  int stall = 0;
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[52:0];
        n_results++;
        if (got.ovld) n_out++;
        if (got.st != ST_OK) n_err++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || m_axis_tdata[55:53] !== 3'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: ip exp %h got %h, status exp %0d got %0d, out exp %b/%h got %b/%h",
                       exp_r.nip, got.nip, exp_r.st, got.st, exp_r.ovld, exp_r.oval,
                       got.ovld, got.oval);
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        m_axis_tready <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        m_axis_tready <= 0;
      end else m_axis_tready <= 1;
    end
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int plens[4];
    m_plen = 0;
    m_ip = 0;
    m_dd = 0;
    m_rd = 0;
    foreach (m_regs[i]) m_regs[i] = 0;
    foreach (m_ram[i]) m_ram[i] = 0;
    foreach (m_dstk[i]) m_dstk[i] = 0;
    foreach (m_rstk[i]) m_rstk[i] = 0;
    // Program length zero: every argument is missing.
    add_instr(OP_PUSH, 5);
    add_instr(OP_POP, 0);
    add_instr(OP_RET, 0);
    add_instr(OP_IN, 0, 32'h8000_0000);
    add_instr(OP_JMP, 0);
    add_cfg(16'hffff);
    add_instr(OP_IN, 0, 32'h7fff_ffff);
    add_instr(OP_SQRT, 0);
    add_instr(OP_OUT, 0);
    add_instr(OP_PUSH, 32'h8000_0000);
    add_instr(OP_PUSH, 32'hffff_ffff);
    add_instr(OP_DIV, 0);
    add_instr(OP_PUSH, 0);
    add_instr(OP_DIV, 0);
    add_instr(OP_SQRT, 0);
    add_instr(OP_MUL, 0);
    add_instr(OP_POPR, 32'hffff_ffff);
    add_instr(OP_PUSH, 7);
    add_instr(OP_POPM, 7);
    add_instr(OP_PUSHM, 3);
    add_instr(OP_PUSHR, 3);
    add_instr(OP_JE, 32'h8000_0000);
    add_instr(OP_CALL, 32'h8000_0000);
    add_instr(OP_CALL, 100);
    add_instr(OP_RET, 0);
    add_instr(OP_SUB, 0);
    add_instr(OP_JMP, 32'h0001_0000);
    add_instr(5'd31, 0);
    plens = '{16, 300, 65535, 2};
    for (int p = 0; p < 4; p++) begin
      add_cfg(16'(plens[p]));
      for (int n = 0; n < 75; n++) begin
        // Two bursts per length: pushes overflow the data stack, then CALLs.
        if (n == 20)
          repeat (66) add_instr(OP_IN, 0, $urandom);
        else if (n == 50)
          repeat (17) add_instr(OP_CALL, $urandom_range(0, plens[p]));
        else add_random(plens[p]);
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    // Pause the sender once midway until every result is back.
    while (jobs.size() >= 300) @(posedge clk_i);
    hold_off = 1;
    while (expected_results.size() != 0) @(posedge clk_i);
    hold_off = 0;
    while (jobs.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d instructions: %0d outputs, %0d error statuses, four program lengths.",
             n_results, n_out, n_err);
    if (mismatches == 0 && expected_results.size() == 0) $display("PASS");
    else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule
